/* design/mhpr_pkg.sv */
// ----------------------------------------------------------------------------
// mhpr_pkg: shared constants for the masked histogram peak ratio core
// Bin count, counter, ratio, divider step counter and output widths.
// ----------------------------------------------------------------------------
package mhpr_pkg;

	localparam int BIN_COUNT       = 256;
	localparam int LEVEL_BITS      = $clog2(BIN_COUNT);
	localparam int PIXEL_BITS      = 8;
	localparam int COUNT_BITS      = 20;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_BITS      = RATIO_FRAC_BITS + 1;
	localparam int DIV_CNT_BITS    = $clog2(RATIO_BITS + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam int OUT_FIELD_BITS = 3 * COUNT_BITS - COUNT_BITS + PIXEL_BITS + RATIO_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

endpackage

/* design/mhpr_hist.sv */
// ----------------------------------------------------------------------------
// mhpr_hist: histogram bin store
// Holds the bin counters in a memory with one registered read port and one
// write port. A fresh bit per bin marks bins written this frame; a bin that
// is not fresh reads as zero, so a frame clear needs only the fresh bits.
// ----------------------------------------------------------------------------
module mhpr_hist
	import mhpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [LEVEL_BITS-1:0] rd_level,
	input  logic                  wr_en,
	input  logic [LEVEL_BITS-1:0] wr_level,
	input  logic                  clear,
	output logic [COUNT_BITS-1:0] next_count
);

	logic [COUNT_BITS-1:0] mem [BIN_COUNT];
	logic [BIN_COUNT-1:0]  fresh_q;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rd_fresh_q;
	logic [COUNT_BITS-1:0] cur_count;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_level];
		end
		if (wr_en) begin
			mem[wr_level] <= next_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q    <= '0;
			rd_fresh_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_fresh_q <= fresh_q[rd_level];
			end
			if (clear) begin
				fresh_q <= '0;
			end else if (wr_en) begin
				fresh_q[wr_level] <= 1'b1;
			end
		end
	end

	// The counter saturates at its top value.
	assign cur_count  = rd_fresh_q ? rd_data_q : '0;
	assign next_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

endmodule

/* design/mhpr_div.sv */
// ----------------------------------------------------------------------------
// mhpr_div: iterative restoring divider
// Computes floor(peak * 2^RATIO_FRAC_BITS / total) one quotient bit per
// cycle, given peak <= total, through one shared compare and subtract.
// ----------------------------------------------------------------------------
module mhpr_div
	import mhpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  done,
	output logic [RATIO_BITS-1:0] quotient
);

	logic [COUNT_BITS:0]     rem_q;
	logic [COUNT_BITS-1:0]   div_q;
	logic [RATIO_BITS-1:0]   quot_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    ge;
	logic [COUNT_BITS:0]     diff;
	logic [COUNT_BITS:0]     rem_next;

	assign ge       = rem_q >= {1'b0, div_q};
	assign diff     = rem_q - {1'b0, div_q};
	assign rem_next = ge ? diff : rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, dividend};
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so the shift cannot overflow.
			rem_q  <= {rem_next[COUNT_BITS-1:0], 1'b0};
			quot_q <= {quot_q[RATIO_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_BITS'(RATIO_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

/* design/masked_histogram_peak_ratio_core.sv */
// ----------------------------------------------------------------------------
// masked_histogram_peak_ratio_core: masked gray histogram with peak ratio
// Counts flagged pixels into a 256-bin histogram and reports the peak bin,
// its lowest level, the total and peak/total in Q1.16 at each frame end.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one pixel per word: tdata holds the gray level,
// tuser the region flag and tlast marks the frame's final pixel. A pixel
// outside the region is taken in the idle state; a pixel inside it first
// reads its bin from the bin memory and then, in the update state, writes it
// back and updates the running peak and total. The block is not ready during
// that update. On the last pixel one result word follows: a check for an
// empty region, the divider (17 quotient bits, one per cycle through its
// single subtractor, then a completion flag; skipped for an empty region)
// and the load of the output register.
// The next frame's first pixel is accepted after the result is loaded.
// A stalled receiver holds the result in the output register; a following
// result waits for that register to drain. Reset clears the bins' fresh
// bits, the running peak and total, and the output valid flag, so the block
// is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module masked_histogram_peak_ratio_core
	import mhpr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [PIXEL_BITS-1:0]    s_axis_tdata,  // [7:0] pixel
	input  logic                     s_axis_tuser,  // [0] in_region
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// [19:0] peak_count, [27:20] peak_level, [47:28] total_count,
	// [64:48] ratio, [71:65] zero
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	output logic                     m_axis_tuser   // [0] empty_res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]            state_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  last_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [LEVEL_BITS-1:0] peak_level_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  empty_q;

	logic                     out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;
	logic                     out_empty_q;

	logic                  accept;
	logic                  hist_rd;
	logic                  hist_wr;
	logic                  out_load;
	logic                  div_start;
	logic                  div_done;
	logic [RATIO_BITS-1:0] div_quot;
	logic [COUNT_BITS-1:0] new_count;
	logic [RATIO_BITS-1:0] ratio;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign hist_rd       = accept && s_axis_tuser;
	assign hist_wr       = (state_q == ST_UPD);
	assign div_start     = (state_q == ST_CHECK) && (total_q != '0);
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign ratio         = empty_q ? '0 : div_quot;

	mhpr_hist u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (hist_rd),
		.rd_level   (s_axis_tdata[LEVEL_BITS-1:0]),
		.wr_en      (hist_wr),
		.wr_level   (level_q),
		.clear      (out_load),
		.next_count (new_count)
	);

	mhpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (peak_q),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			level_q <= s_axis_tdata[LEVEL_BITS-1:0];
		end
		if (out_load) begin
			out_data_q  <= OUT_DATA_BITS'({ratio, total_q, peak_level_q, peak_q});
			out_empty_q <= empty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_q       <= 1'b0;
			peak_q       <= '0;
			peak_level_q <= '0;
			total_q      <= '0;
			empty_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= s_axis_tlast;
						if (s_axis_tuser) begin
							state_q <= ST_UPD;
						end else if (s_axis_tlast) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_UPD: begin
					if (total_q != COUNT_MAX) begin
						total_q <= total_q + 1'b1;
					end
					// Ties go to the lowest level.
					if (new_count > peak_q) begin
						peak_q       <= new_count;
						peak_level_q <= level_q;
					end else if (new_count == peak_q && level_q < peak_level_q) begin
						peak_level_q <= level_q;
					end
					state_q <= last_q ? ST_CHECK : ST_IDLE;
				end
				ST_CHECK: begin
					empty_q <= (total_q == '0);
					state_q <= (total_q == '0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						peak_q       <= '0;
						peak_level_q <= '0;
						total_q      <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_empty_q;

endmodule
